[design/wco_pkg.sv]
// Package for the wall column occlusion block.
// Holds payload structs, command and register codes, the near-clip constant and the corner table.
// No dependencies.
`timescale 1ns / 1ps
package wco_pkg;

  localparam int unsigned ScreenColumns = 320;
  localparam logic signed [31:0] NearClip = 32'sd524288;

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdWall  = 2'd1,
    CmdBox   = 2'd2,
    CmdNone  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] front_floor;
    logic signed [31:0] front_ceiling;
    logic               back_present;
    logic signed [31:0] back_floor;
    logic signed [31:0] back_ceiling;
    logic               no_occlude;
  } item_in_t;

  typedef struct packed {
    logic               visible;
    logic [8:0]         span_start;
    logic signed [31:0] span_end;
    logic               marked_solid;
  } item_out_t;

  typedef enum logic [1:0] {
    RegViewX   = 2'd0,
    RegViewY   = 2'd1,
    RegViewSin = 2'd2,
    RegViewCos = 2'd3
  } reg_e;

  // Corner table: index (byi*4+bxi), returns four 2-bit box indexes packed.
  function automatic logic [7:0] corner_pick(input logic [3:0] pos);
    logic [7:0] r;
    case (pos)
      4'd0:  r = {2'd3, 2'd0, 2'd2, 2'd1};
      4'd1:  r = {2'd3, 2'd0, 2'd2, 2'd0};
      4'd2:  r = {2'd3, 2'd1, 2'd2, 2'd0};
      4'd4:  r = {2'd2, 2'd0, 2'd2, 2'd1};
      4'd6:  r = {2'd3, 2'd1, 2'd3, 2'd0};
      4'd8:  r = {2'd2, 2'd0, 2'd3, 2'd1};
      4'd9:  r = {2'd2, 2'd1, 2'd3, 2'd1};
      4'd10: r = {2'd2, 2'd1, 2'd3, 2'd0};
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

[design/wco_div.sv]
// Serial signed 16.16 divider: (a << 16) / b, truncated, saturated to 32 bits.
// One quotient bit per cycle. Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
module wco_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [31:0] q_o
);

  logic [47:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic [47:0] num_q, num_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic        aneg_q, aneg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [48:0] trial;
  logic [48:0] shifted;
  logic [31:0] amag;
  logic [31:0] bmag;

  assign amag = a_i[31] ? (~a_i + 32'd1) : a_i;
  assign bmag = b_i[31] ? (~b_i + 32'd1) : b_i;
  assign shifted = {rem_q, num_q[47]};
  assign trial = shifted - {17'd0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    num_d = num_q;
    den_d = den_q;
    neg_d = neg_q;
    zero_d = zero_q;
    aneg_d = aneg_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = 48'd0;
      quo_d = 48'd0;
      num_d = {amag, 16'd0};
      den_d = bmag;
      neg_d = a_i[31] ^ b_i[31];
      zero_d = (b_i == 32'sd0);
      aneg_d = a_i[31];
      cnt_d = 6'd0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[48]) begin
        rem_d = trial[47:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = shifted[47:0];
        quo_d = {quo_q[46:0], 1'b0};
      end
      num_d = {num_q[46:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= 6'd0;
    end else begin
      run_q <= run_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    num_q <= num_d;
    den_q <= den_d;
    neg_q <= neg_d;
    zero_q <= zero_d;
    aneg_q <= aneg_d;
  end

  always_comb begin
    if (zero_q) begin
      q_o = aneg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else if (neg_q) begin
      if (quo_q > 48'h80000000) q_o = 32'sh80000000;
      else q_o = 32'(~quo_q + 48'd1);
    end else begin
      if (quo_q > 48'h7FFFFFFF) q_o = 32'sh7FFFFFFF;
      else q_o = quo_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

[design/wco_map.sv]
// Column solid map: one bit per screen column in a single-port memory.
// One access per cycle with registered read data. Uses wco_pkg for the default width.
`timescale 1ns / 1ps
module wco_map #(
  parameter int unsigned Cols = wco_pkg::ScreenColumns
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic                     wdata_i,
  input  logic [$clog2(Cols)-1:0]  idx_i,
  output logic                     rdata_o
);

  logic mem_q [Cols];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[idx_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdata_q <= 1'b0;
    end else if (re_i) begin
      rdata_q <= mem_q[idx_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/wall_column_occlusion.sv]
// Top level of the wall column occlusion block.
// Uses wco_pkg, wco_div (serial divider) and wco_map (column map).
//
// Usage: an item is given on item_i with start high while busy is low.
// Walls and boxes are transformed to view space and culled. Walls are then
// clipped to the near plane at 8.0, boxes to the view edges x = -y and x = y,
// and both are projected with the shared serial divider. The covered columns
// are then scanned, and for closed walls filled, one column per cycle.
// Exactly one result is shown on result_o with done_o high for one cycle per
// item; the receiver cannot stall it. A clear item wipes the map one column
// per cycle. A wall passes through the transform, the near clip if needed,
// the two projections, the scan, the fill if needed and the output. A box
// passes through the transform, up to two clips, the two projections, the
// scan and the output. An unknown command goes straight to the output.
// done_o rises in the cycle busy falls, and the next item can be accepted in
// that cycle; items are handled one at a time. Reset starts the same wipe
// with busy high and sets the view registers to x = 0, y = 0, sine = 0,
// cosine = 1.0. The user must write the view registers over the APB port only
// while busy is low; the block itself does not enforce this.
`timescale 1ns / 1ps
module wall_column_occlusion #(
  parameter int unsigned SCREEN_COLUMNS = wco_pkg::ScreenColumns
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  wco_pkg::item_in_t  item_i,
  output logic               done_o,
  output wco_pkg::item_out_t result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IdxW = $clog2(SCREEN_COLUMNS);
  localparam int unsigned ColW = $clog2(SCREEN_COLUMNS + 1);
  localparam logic signed [31:0] Cols32 = 32'(SCREEN_COLUMNS);
  localparam logic signed [31:0] Half32 = 32'(SCREEN_COLUMNS / 2);

  typedef enum logic [4:0] {
    StIdle, StInit, StClear, StDx, StM0, StM1, StM2, StM3, StV1, StV2, StCull,
    StBoxC, StClipA, StClipDiv, StClipMul, StClipFix, StClipB, StClipBDiv,
    StClipBMul, StClipBFix, StPrj1, StPrj1W, StPrj2, StPrj2W, StScan, StFill,
    StOut
  } state_e;

  state_e state_q;
  logic signed [31:0] vx_q, vy_q;
  logic signed [17:0] vs_q, vc_q;
  wco_pkg::item_in_t it_q;
  logic signed [31:0] px_q, py_q, dx_q, dy_q, p0_q, p1_q, p2_q, p3_q;
  logic signed [31:0] x1_q, y1_q, x2_q, y2_q, xs_q, xe_q, t_q;
  logic pt_q, vis_q, mark_q, fill_q, box_q, rd_v_q;
  logic [ColW-1:0] col_q;
  logic [ColW-1:0] col_start;
  logic signed [31:0] col32;
  logic scan_hit, scan_go;
  logic div_go;
  logic signed [31:0] div_a, div_b, div_q;
  logic div_done;
  logic map_re, map_we, map_wdata, map_bit;
  logic [IdxW-1:0] map_idx;

  // Shared multiplier: 32 x 32 signed, result >> 16 truncated to 32 bits.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [31:0] mul_r;
  assign mul_p = mul_a * mul_b;
  assign mul_r = mul_p[47:16];

  function automatic logic signed [31:0] prj(input logic signed [31:0] q);
    return (q >>> 9) + (q >>> 11) + Half32;
  endfunction

  logic signed [31:0] neg_y1, neg_y2;
  assign neg_y1 = -y1_q;
  assign neg_y2 = -y2_q;
  logic signed [31:0] cross_v;
  logic signed [15:0] hx1, hy1, hx2, hy2;
  assign hx1 = x1_q[31:16];
  assign hy1 = y1_q[31:16];
  assign hx2 = x2_q[31:16];
  assign hy2 = y2_q[31:16];
  assign cross_v = 32'(hx2 * hy1) - 32'(hx1 * hy2);

  logic [1:0] bxi, byi;
  logic [3:0] pos;
  logic [7:0] pick;
  always_comb begin
    bxi = (vx_q < it_q.ax) ? 2'd0 : ((vx_q <= it_q.bx) ? 2'd1 : 2'd2);
    byi = (vy_q > it_q.ay) ? 2'd0 : ((vy_q >= it_q.by) ? 2'd1 : 2'd2);
    pos = {byi, 2'b00} + {2'b00, bxi};
    pick = wco_pkg::corner_pick(pos);
  end

  function automatic logic signed [31:0] boxv(input wco_pkg::item_in_t it,
                                              input logic [1:0] k);
    logic signed [31:0] r;
    case (k)
      2'd0: r = it.ay;
      2'd1: r = it.by;
      2'd2: r = it.ax;
      default: r = it.bx;
    endcase
    return r;
  endfunction

  logic occl;
  assign occl = !it_q.no_occlude && (!it_q.back_present
      || it_q.back_ceiling <= it_q.front_floor || it_q.back_floor >= it_q.front_ceiling
      || it_q.back_floor == it_q.back_ceiling);

  wco_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  wco_map #(.Cols(SCREEN_COLUMNS)) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (map_re),
    .we_i    (map_we),
    .wdata_i (map_wdata),
    .idx_i   (map_idx),
    .rdata_o (map_bit)
  );

  assign col32 = $signed({{(32 - ColW){1'b0}}, col_q});
  assign col_start = (xs_q > Cols32) ? ColW'(SCREEN_COLUMNS) : xs_q[ColW-1:0];
  assign scan_hit = rd_v_q && !map_bit;
  assign scan_go = (col32 < xe_q) && !vis_q && !scan_hit;
  assign map_idx = col_q[IdxW-1:0];
  assign map_re = (state_q == StScan) && scan_go;
  assign map_we = (state_q == StInit) || (state_q == StClear)
      || ((state_q == StFill) && (col32 < xe_q));
  assign map_wdata = (state_q == StFill);
  assign busy = (state_q != StIdle);
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      wco_pkg::RegViewX:   prdata = vx_q;
      wco_pkg::RegViewY:   prdata = vy_q;
      wco_pkg::RegViewSin: prdata = {{14{vs_q[17]}}, vs_q};
      default:             prdata = {{14{vc_q[17]}}, vc_q};
    endcase
  end

  always_comb begin
    mul_a = {{14{vs_q[17]}}, vs_q};
    mul_b = dx_q;
    div_go = 1'b0;
    div_a = x1_q;
    div_b = y1_q;
    case (state_q)
      StM0: begin mul_a = {{14{vs_q[17]}}, vs_q}; mul_b = dx_q; end
      StM1: begin mul_a = {{14{vc_q[17]}}, vc_q}; mul_b = dy_q; end
      StM2: begin mul_a = {{14{vc_q[17]}}, vc_q}; mul_b = dx_q; end
      StM3: begin mul_a = {{14{vs_q[17]}}, vs_q}; mul_b = dy_q; end
      StClipMul, StClipBMul: begin mul_a = div_q; mul_b = t_q; end
      StClipA: begin
        div_go = 1'b1;
        if (box_q) begin
          div_a = x1_q + y1_q;
          div_b = x1_q + y1_q - x2_q - y2_q;
        end else if (y1_q < wco_pkg::NearClip) begin
          div_a = wco_pkg::NearClip - y1_q;
          div_b = y2_q - y1_q;
        end else begin
          div_a = wco_pkg::NearClip - y2_q;
          div_b = y1_q - y2_q;
        end
      end
      StClipB: begin
        div_go = 1'b1;
        div_a = x1_q - y1_q;
        div_b = x1_q - y1_q - x2_q + y2_q;
      end
      StPrj1: begin div_go = 1'b1; div_a = x1_q; div_b = y1_q; end
      StPrj2: begin div_go = 1'b1; div_a = x2_q; div_b = y2_q; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      col_q <= '0;
      vx_q <= 32'sd0;
      vy_q <= 32'sd0;
      vs_q <= 18'sd0;
      vc_q <= 18'sd65536;
      done_o <= 1'b0;
      pt_q <= 1'b0;
      rd_v_q <= 1'b0;
      result_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          wco_pkg::RegViewX:   vx_q <= pwdata;
          wco_pkg::RegViewY:   vy_q <= pwdata;
          wco_pkg::RegViewSin: vs_q <= pwdata[17:0];
          default:             vc_q <= pwdata[17:0];
        endcase
      end
      case (state_q)
        StIdle: begin
          if (start) begin
            it_q <= item_i;
            vis_q <= 1'b0;
            mark_q <= 1'b0;
            xs_q <= 32'sd0;
            xe_q <= 32'sd0;
            pt_q <= 1'b0;
            col_q <= '0;
            box_q <= (item_i.cmd == wco_pkg::CmdBox);
            px_q <= item_i.ax;
            py_q <= item_i.ay;
            case (item_i.cmd)
              wco_pkg::CmdClear: state_q <= StClear;
              wco_pkg::CmdWall:  state_q <= StDx;
              wco_pkg::CmdBox:   state_q <= StBoxC;
              default:           state_q <= StOut;
            endcase
          end
        end
        StInit, StClear: begin
          if (col_q == ColW'(SCREEN_COLUMNS - 1)) begin
            col_q <= '0;
            state_q <= (state_q == StInit) ? StIdle : StOut;
          end else begin
            col_q <= col_q + ColW'(1);
          end
        end
        StBoxC: begin
          if (pos == 4'd5) begin
            vis_q <= 1'b1;
            state_q <= StOut;
          end else begin
            px_q <= boxv(it_q, pick[7:6]);
            py_q <= boxv(it_q, pick[5:4]);
            state_q <= StDx;
          end
        end
        StDx: begin
          dx_q <= px_q - vx_q;
          dy_q <= py_q - vy_q;
          state_q <= StM0;
        end
        StM0: begin p0_q <= mul_r; state_q <= StM1; end
        StM1: begin p1_q <= mul_r; state_q <= StM2; end
        StM2: begin p2_q <= mul_r; state_q <= StM3; end
        StM3: begin p3_q <= mul_r; state_q <= pt_q ? StV2 : StV1; end
        StV1: begin
          x1_q <= p0_q - p1_q;
          y1_q <= p2_q + p3_q;
          pt_q <= 1'b1;
          if (box_q) begin
            px_q <= boxv(it_q, pick[3:2]);
            py_q <= boxv(it_q, pick[1:0]);
          end else begin
            px_q <= it_q.bx;
            py_q <= it_q.by;
          end
          state_q <= StDx;
        end
        StV2: begin
          x2_q <= p0_q - p1_q;
          y2_q <= p2_q + p3_q;
          state_q <= StCull;
        end
        StCull: begin
          if ((x1_q < neg_y1 && x2_q < neg_y2) || (y1_q < x1_q && y2_q < x2_q)) begin
            state_q <= StOut;
          end else if (box_q) begin
            if (cross_v < 32'sd2) begin
              vis_q <= 1'b1;
              state_q <= StOut;
            end else if (y1_q <= 32'sd0 && y2_q <= 32'sd0) begin
              state_q <= StOut;
            end else if (x1_q < neg_y1) begin
              t_q <= y2_q - y1_q;
              state_q <= StClipA;
            end else begin
              state_q <= StClipFix;
            end
          end else if ((y1_q < wco_pkg::NearClip + 32'sd1
                        && y2_q < wco_pkg::NearClip + 32'sd1)
                       || cross_v <= 32'sd0) begin
            state_q <= StOut;
          end else if (y1_q < wco_pkg::NearClip) begin
            t_q <= x2_q - x1_q;
            state_q <= StClipA;
          end else if (y2_q < wco_pkg::NearClip) begin
            t_q <= x1_q - x2_q;
            state_q <= StClipA;
          end else begin
            state_q <= StPrj1;
          end
        end
        StClipA: state_q <= StClipDiv;
        StClipDiv: if (div_done) state_q <= StClipMul;
        StClipMul: begin
          if (box_q) begin
            y1_q <= y1_q + mul_r;
            x1_q <= -(y1_q + mul_r);
            state_q <= StClipFix;
          end else if (y1_q < wco_pkg::NearClip) begin
            x1_q <= x1_q + mul_r;
            y1_q <= wco_pkg::NearClip;
            state_q <= StPrj1;
          end else begin
            x2_q <= x2_q + mul_r;
            y2_q <= wco_pkg::NearClip;
            state_q <= StPrj1;
          end
        end
        StClipFix: begin
          if (y2_q < x2_q) begin
            t_q <= y2_q - y1_q;
            state_q <= StClipB;
          end else begin
            state_q <= StPrj1;
          end
        end
        StClipB: state_q <= StClipBDiv;
        StClipBDiv: if (div_done) state_q <= StClipBMul;
        StClipBMul: begin
          x2_q <= mul_r + y1_q;
          y2_q <= mul_r + y1_q;
          state_q <= StClipBFix;
        end
        StClipBFix: state_q <= StPrj1;
        StPrj1: state_q <= StPrj1W;
        StPrj1W: begin
          if (div_done) begin
            xs_q <= (prj(div_q) < 32'sd0) ? 32'sd0 : prj(div_q);
            state_q <= StPrj2;
          end
        end
        StPrj2: state_q <= StPrj2W;
        StPrj2W: begin
          if (div_done) begin
            xe_q <= (prj(div_q) >= Cols32) ? Cols32 : prj(div_q);
            col_q <= col_start;
            rd_v_q <= 1'b0;
            state_q <= StScan;
          end
        end
        StScan: begin
          if (scan_hit) vis_q <= 1'b1;
          if (scan_go) begin
            rd_v_q <= 1'b1;
            col_q <= col_q + ColW'(1);
          end else begin
            rd_v_q <= 1'b0;
            col_q <= col_start;
            fill_q <= !box_q && occl;
            state_q <= (!box_q && occl) ? StFill : StOut;
          end
        end
        StFill: begin
          if (col32 < xe_q) begin
            mark_q <= 1'b1;
            col_q <= col_q + ColW'(1);
          end else begin
            state_q <= StOut;
          end
        end
        StOut: begin
          done_o <= 1'b1;
          result_o.visible <= vis_q;
          result_o.span_start <= box_q ? 9'd0 :
              ((xs_q > Cols32) ? 9'(SCREEN_COLUMNS) : xs_q[8:0]);
          result_o.span_end <= box_q ? 32'sd0 : xe_q;
          result_o.marked_solid <= mark_q && fill_q;
          fill_q <= 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
